>>> sv/frr_pkg.sv
// Shared types, constants and the CRC-8 step function of the framed reply receiver.
package frr_pkg;

   // Fixed field widths of the channels.
   localparam int KIND_W    = 2;
   localparam int BYTE_W    = 8;
   localparam int TICKS_W   = 16;
   localparam int STATUS_W  = 3;
   localparam int LEN_W     = 6;
   localparam int CSR_IDX_W = 3;

   // Generator polynomial of the CRC-8, x^8 + x^2 + x + 1.
   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
   localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

   // Input item kinds.
   typedef enum logic [KIND_W-1:0] {
      KIND_BYTE  = 2'd0,
      KIND_TICK  = 2'd1,
      KIND_START = 2'd2
   } frr_kind_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_ACK     = 3'd0,
      ST_DATA    = 3'd1,
      ST_CRC_ERR = 3'd2,
      ST_NACK    = 3'd3,
      ST_TIMEOUT = 3'd4
   } frr_status_code_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYNC_FIRST  = 3'd0,
      CSR_SYNC_SECOND = 3'd1,
      CSR_ACK_CODE    = 3'd2,
      CSR_PONG_CODE   = 3'd3,
      CSR_DATA_CODE   = 3'd4
   } frr_csr_index_type;

   // Configuration register reset values.
   localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;
   localparam logic [BYTE_W-1:0] ACK_CODE_RST    = 8'h80;
   localparam logic [BYTE_W-1:0] PONG_CODE_RST   = 8'h81;
   localparam logic [BYTE_W-1:0] DATA_CODE_RST   = 8'h82;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_HUNT,
      S_SYNC2,
      S_CODE,
      S_LEN,
      S_BODY,
      S_READ,
      S_READ_WAIT
   } frr_state_type;

   // Source of a result loaded into the output register.
   typedef enum logic [1:0] {
      OUT_TIMEOUT,
      OUT_FRAME,
      OUT_PAYLOAD
   } frr_out_sel_type;

   // Configuration register contents.
   typedef struct packed {
      logic [BYTE_W-1:0] sync_first;
      logic [BYTE_W-1:0] sync_second;
      logic [BYTE_W-1:0] ack_code;
      logic [BYTE_W-1:0] pong_code;
      logic [BYTE_W-1:0] data_code;
   } frr_cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            start;
      logic            tick_inc;
      logic            load_code;
      logic            load_len;
      logic            store_byte;
      logic            read_init;
      logic            read_issue;
      logic            out_load;
      frr_out_sel_type out_sel;
   } frr_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic limit_zero;
      logic tick_expire;
      logic is_sync1;
      logic is_sync2;
      logic len_too_big;
      logic body_more;
      logic frame_single;
      logic read_last;
      logic out_free;
   } frr_status_type;

   // One byte step of the CRC-8, most significant bit first.
   function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> sv/frr_if.sv
// Channel interfaces of the framed reply receiver: request, response and register write.

// Request channel: received bytes, ticks and start items.
interface frr_req_if;
   logic                         valid;
   logic                         ready;
   logic [frr_pkg::KIND_W-1:0]   kind;
   logic [frr_pkg::BYTE_W-1:0]   rx_byte;
   logic [frr_pkg::TICKS_W-1:0]  timeout_ticks;

   modport source (output valid, kind, rx_byte, timeout_ticks, input ready);
   modport sink   (input valid, kind, rx_byte, timeout_ticks, output ready);
endinterface

// Response channel: one result per transfer.
interface frr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [frr_pkg::STATUS_W-1:0]  status;
   logic [frr_pkg::BYTE_W-1:0]    reply_code;
   logic [frr_pkg::LEN_W-1:0]     reply_length;
   logic [frr_pkg::BYTE_W-1:0]    payload_byte;
   logic                          last;

   modport source (output valid, status, reply_code, reply_length, payload_byte, last,
                   input ready);
   modport sink   (input valid, status, reply_code, reply_length, payload_byte, last,
                   output ready);
endinterface

// Register write channel.
interface frr_csr_if;
   logic                           valid;
   logic                           ready;
   logic [frr_pkg::CSR_IDX_W-1:0]  index;
   logic [frr_pkg::BYTE_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/frr_csr.sv
// Configuration registers of the framed reply receiver.
module frr_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [frr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [frr_pkg::BYTE_W-1:0]    csr_data,
   output frr_pkg::frr_cfg_type          cfg
);

   frr_pkg::frr_cfg_type cfg_ff;
   frr_pkg::frr_cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the register index; indexes past the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (frr_pkg::frr_csr_index_type'(csr_index))
            frr_pkg::CSR_SYNC_FIRST:  cfg_in.sync_first  = csr_data;
            frr_pkg::CSR_SYNC_SECOND: cfg_in.sync_second = csr_data;
            frr_pkg::CSR_ACK_CODE:    cfg_in.ack_code    = csr_data;
            frr_pkg::CSR_PONG_CODE:   cfg_in.pong_code   = csr_data;
            frr_pkg::CSR_DATA_CODE:   cfg_in.data_code   = csr_data;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first  <= frr_pkg::SYNC_FIRST_RST;
         cfg_ff.sync_second <= frr_pkg::SYNC_SECOND_RST;
         cfg_ff.ack_code    <= frr_pkg::ACK_CODE_RST;
         cfg_ff.pong_code   <= frr_pkg::PONG_CODE_RST;
         cfg_ff.data_code   <= frr_pkg::DATA_CODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> sv/frr_ctrl.sv
// Controller state machine of the framed reply receiver.
module frr_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [frr_pkg::KIND_W-1:0]  req_kind,
   output logic                        req_ready,
   input  frr_pkg::frr_status_type     status,
   output frr_pkg::frr_cmd_type        cmd
);

   frr_pkg::frr_state_type state_ff;
   frr_pkg::frr_state_type state_in;
   logic                   accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= frr_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.out_sel = frr_pkg::OUT_TIMEOUT;
      // Input is held off during read-out and while a result cannot be replaced.
      req_ready = status.out_free && (state_ff != frr_pkg::S_READ) &&
                  (state_ff != frr_pkg::S_READ_WAIT);
      accept    = req_valid && req_ready;

      unique case (state_ff)
         frr_pkg::S_READ: begin
            if (status.out_free) begin
               cmd.read_issue = 1'b1;
               state_in       = frr_pkg::S_READ_WAIT;
            end
         end
         frr_pkg::S_READ_WAIT: begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = frr_pkg::OUT_PAYLOAD;
            state_in     = status.read_last ? frr_pkg::S_IDLE : frr_pkg::S_READ;
         end
         default: begin
            if (accept) begin
               case (frr_pkg::frr_kind_type'(req_kind))
                  frr_pkg::KIND_START: begin
                     cmd.start = 1'b1;
                     if (status.limit_zero) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = frr_pkg::OUT_TIMEOUT;
                        state_in     = frr_pkg::S_IDLE;
                     end else begin
                        state_in = frr_pkg::S_HUNT;
                     end
                  end
                  frr_pkg::KIND_TICK: begin
                     if (state_ff != frr_pkg::S_IDLE) begin
                        cmd.tick_inc = 1'b1;
                        if (status.tick_expire) begin
                           cmd.out_load = 1'b1;
                           cmd.out_sel  = frr_pkg::OUT_TIMEOUT;
                           state_in     = frr_pkg::S_IDLE;
                        end
                     end
                  end
                  frr_pkg::KIND_BYTE: begin
                     unique case (state_ff)
                        frr_pkg::S_HUNT: begin
                           if (status.is_sync1) begin
                              state_in = frr_pkg::S_SYNC2;
                           end
                        end
                        frr_pkg::S_SYNC2: begin
                           state_in = status.is_sync2 ? frr_pkg::S_CODE : frr_pkg::S_HUNT;
                        end
                        frr_pkg::S_CODE: begin
                           cmd.load_code = 1'b1;
                           state_in      = frr_pkg::S_LEN;
                        end
                        frr_pkg::S_LEN: begin
                           if (status.len_too_big) begin
                              state_in = frr_pkg::S_HUNT;
                           end else begin
                              cmd.load_len = 1'b1;
                              state_in     = frr_pkg::S_BODY;
                           end
                        end
                        frr_pkg::S_BODY: begin
                           if (status.body_more) begin
                              cmd.store_byte = 1'b1;
                           end else if (status.frame_single) begin
                              // CRC byte: error, unknown code or empty payload.
                              cmd.out_load = 1'b1;
                              cmd.out_sel  = frr_pkg::OUT_FRAME;
                              state_in     = frr_pkg::S_IDLE;
                           end else begin
                              cmd.read_init = 1'b1;
                              state_in      = frr_pkg::S_READ;
                           end
                        end
                        default: state_in = state_ff;
                     endcase
                  end
                  default: state_in = state_ff;
               endcase
            end
         end
      endcase
   end

endmodule

>>> sv/frr_datapath.sv
// Datapath of the framed reply receiver: tick counter, CRC, payload store and result register.
module frr_datapath #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  frr_pkg::frr_cfg_type          cfg,
   input  frr_pkg::frr_cmd_type          cmd,
   output frr_pkg::frr_status_type       status,
   input  logic [frr_pkg::BYTE_W-1:0]    req_rx_byte,
   input  logic [frr_pkg::TICKS_W-1:0]   req_timeout_ticks,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [frr_pkg::STATUS_W-1:0]  rsp_status,
   output logic [frr_pkg::BYTE_W-1:0]    rsp_reply_code,
   output logic [frr_pkg::LEN_W-1:0]     rsp_reply_length,
   output logic [frr_pkg::BYTE_W-1:0]    rsp_payload_byte,
   output logic                          rsp_last
);

   localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);
   localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   logic [frr_pkg::TICKS_W-1:0] elapsed_ff, elapsed_in, elapsed_inc;
   logic [frr_pkg::TICKS_W-1:0] limit_ff, limit_in;
   logic [frr_pkg::BYTE_W-1:0]  crc_ff, crc_in, crc_base;
   logic [frr_pkg::BYTE_W-1:0]  code_ff, code_in;
   logic [frr_pkg::LEN_W-1:0]   len_ff, len_in;
   logic [CNT_W-1:0]            idx_ff, idx_in;
   logic [frr_pkg::LEN_W-1:0]   idx_len;
   logic [frr_pkg::BYTE_W-1:0]  rd_data_ff;
   logic [frr_pkg::BYTE_W-1:0]  store_mem [MAX_PAYLOAD];

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [frr_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [frr_pkg::BYTE_W-1:0]  rsp_code_ff, rsp_code_in;
   logic [frr_pkg::LEN_W-1:0]   rsp_len_ff, rsp_len_in;
   logic [frr_pkg::BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        crc_ok;
   frr_pkg::frr_status_code_type code_class;

   assign elapsed_inc = elapsed_ff + 16'd1;
   assign idx_len     = frr_pkg::LEN_W'(idx_ff);
   assign crc_base    = cmd.load_code ? frr_pkg::CRC_INIT : crc_ff;
   assign crc_ok      = (req_rx_byte == crc_ff);

   // Classify the held command byte.
   always_comb begin
      if (code_ff == cfg.ack_code || code_ff == cfg.pong_code) begin
         code_class = frr_pkg::ST_ACK;
      end else if (code_ff == cfg.data_code) begin
         code_class = frr_pkg::ST_DATA;
      end else begin
         code_class = frr_pkg::ST_NACK;
      end
   end

   // Status to the controller.
   always_comb begin
      status.limit_zero   = (req_timeout_ticks == '0);
      status.tick_expire  = (elapsed_inc >= limit_ff);
      status.is_sync1     = (req_rx_byte == cfg.sync_first);
      status.is_sync2     = (req_rx_byte == cfg.sync_second);
      status.len_too_big  = (req_rx_byte > frr_pkg::BYTE_W'(MAX_PAYLOAD));
      status.body_more    = (idx_len < len_ff);
      status.frame_single = !crc_ok || (code_class == frr_pkg::ST_NACK) || (len_ff == '0);
      status.read_last    = ((idx_len + 6'd1) == len_ff);
      status.out_free     = !rsp_valid_ff || rsp_ready;
   end

   // Frame and timer registers.
   always_comb begin
      elapsed_in = elapsed_ff;
      limit_in   = limit_ff;
      crc_in     = crc_ff;
      code_in    = code_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      if (cmd.start) begin
         elapsed_in = '0;
         limit_in   = req_timeout_ticks;
         crc_in     = frr_pkg::CRC_INIT;
      end
      if (cmd.tick_inc) begin
         elapsed_in = elapsed_inc;
      end
      if (cmd.load_code) begin
         code_in = req_rx_byte;
         idx_in  = '0;
      end
      if (cmd.load_len) begin
         len_in = req_rx_byte[frr_pkg::LEN_W-1:0];
      end
      if (cmd.load_code || cmd.load_len || cmd.store_byte) begin
         crc_in = frr_pkg::crc8_update(crc_base, req_rx_byte);
      end
      if (cmd.store_byte) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.read_init) begin
         idx_in = '0;
      end
      if (cmd.out_load && cmd.out_sel == frr_pkg::OUT_PAYLOAD) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         limit_ff   <= '0;
         crc_ff     <= '0;
         code_ff    <= '0;
         len_ff     <= '0;
         idx_ff     <= '0;
      end else begin
         elapsed_ff <= elapsed_in;
         limit_ff   <= limit_in;
         crc_ff     <= crc_in;
         code_ff    <= code_in;
         len_ff     <= len_in;
         idx_ff     <= idx_in;
      end
   end

   // Payload store: one write or one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.store_byte) begin
         store_mem[idx_ff[ADDR_W-1:0]] <= req_rx_byte;
      end
      if (cmd.read_issue) begin
         rd_data_ff <= store_mem[idx_ff[ADDR_W-1:0]];
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         case (cmd.out_sel)
            frr_pkg::OUT_FRAME: begin
               rsp_status_in = crc_ok ? code_class : frr_pkg::ST_CRC_ERR;
               rsp_code_in   = code_ff;
               rsp_len_in    = len_ff;
               rsp_byte_in   = '0;
               rsp_last_in   = 1'b1;
            end
            frr_pkg::OUT_PAYLOAD: begin
               rsp_status_in = code_class;
               rsp_code_in   = code_ff;
               rsp_len_in    = len_ff;
               rsp_byte_in   = rd_data_ff;
               rsp_last_in   = status.read_last;
            end
            default: begin
               rsp_status_in = frr_pkg::ST_TIMEOUT;
               rsp_code_in   = '0;
               rsp_len_in    = '0;
               rsp_byte_in   = '0;
               rsp_last_in   = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_reply_code   = rsp_code_ff;
   assign rsp_reply_length = rsp_len_ff;
   assign rsp_payload_byte = rsp_byte_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

>>> sv/framed_reply_receiver.sv
// Top level of the framed reply receiver: register block, controller and datapath.
//
//   Channel  Direction  Carries
//   req_ch   in         kind, rx_byte, timeout_ticks
//   rsp_ch   out        status, reply_code, reply_length, payload_byte, last
//   csr_ch   in         index, data (register write)
//
// A new byte, tick or start item may be taken every cycle while input is not held off.
// An accepted frame with payload is read out of the single-port payload store byte by
// byte, each by a read and then a load into the result register; no input is taken then.
// The result register holds a result until it is taken; an input item is taken only
// when that register is empty or emptying in the same cycle.
// Synchronous reset clears control state; the payload store needs no clearing pass.
module framed_reply_receiver #(
   parameter int MAX_PAYLOAD = 32
) (
   input logic      clock,
   input logic      reset,
   frr_req_if.sink  req_ch,
   frr_rsp_if.source rsp_ch,
   frr_csr_if.sink  csr_ch
);

   frr_pkg::frr_cfg_type    cfg;
   frr_pkg::frr_cmd_type    cmd;
   frr_pkg::frr_status_type status;

   // Configuration registers.
   frr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_ch.valid),
      .csr_ready (csr_ch.ready),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .cfg       (cfg)
   );

   // Frame sequencing.
   frr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (req_ch.kind),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Counters, CRC, payload store and result register.
   frr_datapath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .status            (status),
      .req_rx_byte       (req_ch.rx_byte),
      .req_timeout_ticks (req_ch.timeout_ticks),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_status        (rsp_ch.status),
      .rsp_reply_code    (rsp_ch.reply_code),
      .rsp_reply_length  (rsp_ch.reply_length),
      .rsp_payload_byte  (rsp_ch.payload_byte),
      .rsp_last          (rsp_ch.last)
   );

endmodule
